### hdl/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg - shared types and helpers for the S-record stream decoder
// Result kinds, register indexes, configuration and result records, and the
// small character decoders used by the decode core.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_REGION_START = 2'd0,
        REG_REGION_END   = 2'd1,
        REG_STRAY_LIMIT  = 2'd2
    } reg_index_t;

    localparam logic [31:0] REGION_START_RESET = 32'h0000_A000;
    localparam logic [31:0] REGION_END_RESET   = 32'h0000_C800;
    localparam logic [7:0]  STRAY_LIMIT_RESET  = 8'd200;

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_4    = 8'h34;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;
    localparam logic [3:0] TYPE_BAD  = 4'hF;
    localparam logic [7:0] SUM_GOOD  = 8'hFF;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_OK    = 3'd1,
        KIND_END   = 3'd2,
        KIND_BAD   = 3'd3,
        KIND_RANGE = 3'd4,
        KIND_SYNC  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [7:0]  stray_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] byte_address;
        logic [7:0]  data_value;
        logic [7:0]  data_count;
    } result_t;

    // {valid, nibble}; a non-hex character gives nibble zero
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = c - CHAR_UA + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_LA && c <= CHAR_LF) begin
            d = c - CHAR_LA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // address field length in bytes for a record type
    function automatic logic [2:0] addr_bytes(input logic [3:0] t);
        case (t)
            4'd2, 4'd6, 4'd8: return 3'd3;
            4'd3, 4'd7:       return 3'd4;
            default:          return 3'd2;
        endcase
    endfunction

endpackage

### hdl/srecord_stream_decoder.sv
// ----------------------------------------------------------------------------
// srecord_stream_decoder - Motorola S-record stream decoder
// Decodes one ASCII character per word into data bytes with addresses and
// one verdict per line; halts on error or end record until reset.
//
//   channel   direction  handshake                payload
//   input     in         in_valid / in_ready      rx_char
//   output    out        out_valid / out_ready    kind, byte_address,
//                                                 data_value, data_count
//   config    in         cfg_write                cfg_index, cfg_data
//
// One character per cycle while the output is not stalled; an accepted character
// passes the input register, then is decoded into the result register.
// The input register advances whenever the result register is empty or
// being taken, so a stalled output holds at most one word on each side.
// Reset clears the line state, the halt flag and the registers to their
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module srecord_stream_decoder #(
    parameter int unsigned MAX_LINE_BYTES = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] byte_address,
    output logic [7:0]  data_value,
    output logic [7:0]  data_count,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    srd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       char_reg;
    logic             out_valid_reg;
    srd_pkg::result_t out_reg;
    logic             advance;
    logic             res_valid;
    srd_pkg::result_t res;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    assign kind         = out_reg.kind;
    assign byte_address = out_reg.byte_address;
    assign data_value   = out_reg.data_value;
    assign data_count   = out_reg.data_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.region_start <= srd_pkg::REGION_START_RESET;
            cfg_reg.region_end   <= srd_pkg::REGION_END_RESET;
            cfg_reg.stray_limit  <= srd_pkg::STRAY_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                srd_pkg::REG_REGION_START: cfg_reg.region_start <= cfg_data;
                srd_pkg::REG_REGION_END:   cfg_reg.region_end   <= cfg_data;
                srd_pkg::REG_STRAY_LIMIT:  cfg_reg.stray_limit  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register: hold the word until the decode step takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= rx_char;
        end
    end

    srd_core #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_char   (char_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register: load on a step, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    // a pending result is never overwritten while stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    // the result register follows the decode step
    a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg == $past(res_valid)))
        else $error("result register out of step with decoder");

    // data words carry no line count
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == srd_pkg::KIND_DATA) |-> (out_reg.data_count == 8'd0))
        else $error("data word with a non-zero count");

endmodule

### hdl/srd_core.sv
// ----------------------------------------------------------------------------
// srd_core - S-record decode state and per-character update
// Holds the line state and works out, for one character, the next state and
// the result word (if any) it produces.
// ----------------------------------------------------------------------------
module srd_core #(
    parameter int unsigned MAX_LINE_BYTES = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_char,
    input  srd_pkg::cfg_t    cfg,
    output logic             res_valid,
    output srd_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_COUNT = 3'd2,
        PH_BODY  = 3'd3,
        PH_TERM1 = 3'd4,
        PH_TERM2 = 3'd5
    } phase_t;

    localparam logic [7:0] MAX_BYTES = 8'(MAX_LINE_BYTES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  length_reg, length_next;
    logic [31:0] start_reg, start_next;
    logic [3:0]  high_reg, high_next;
    logic        pend_reg, pend_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  stray_reg, stray_next;
    logic        bad_reg, bad_next;
    logic        halted_reg, halted_next;

    logic [4:0]  hex;
    logic [7:0]  byte_val;
    logic [7:0]  pos;
    logic [7:0]  left_dec;
    logic [7:0]  sum_add;
    logic [2:0]  abytes;
    logic        data_type;
    logic [32:0] end_point;
    logic [7:0]  type_off;

    always_comb
    begin
        hex       = srd_pkg::hex_nibble(rx_char);
        byte_val  = {high_reg, hex[3:0]};
        abytes    = srd_pkg::addr_bytes(type_reg);
        pos       = length_reg - left_reg;
        left_dec  = left_reg - 8'd1;
        sum_add   = sum_reg + byte_val;
        data_type = (type_reg >= 4'd1) && (type_reg <= 4'd3);
        end_point = {1'b0, start_reg} + {25'd0, index_reg};
        type_off  = rx_char - srd_pkg::CHAR_0;

        phase_next  = phase_reg;
        type_next   = type_reg;
        left_next   = left_reg;
        length_next = length_reg;
        start_next  = start_reg;
        high_next   = high_reg;
        pend_next   = pend_reg;
        sum_next    = sum_reg;
        index_next  = index_reg;
        stray_next  = stray_reg;
        bad_next    = bad_reg;
        halted_next = halted_reg;

        res_valid        = 1'b0;
        res.kind         = srd_pkg::KIND_DATA;
        res.byte_address = 32'd0;
        res.data_value   = 8'd0;
        res.data_count   = 8'd0;

        if (step && !halted_reg) begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_char == srd_pkg::CHAR_S) begin
                        stray_next  = 8'd0;
                        type_next   = 4'd0;
                        left_next   = 8'd0;
                        length_next = 8'd0;
                        start_next  = 32'd0;
                        high_next   = 4'd0;
                        pend_next   = 1'b0;
                        sum_next    = 8'd0;
                        index_next  = 8'd0;
                        bad_next    = 1'b0;
                        phase_next  = PH_TYPE;
                    end else if (stray_reg >= cfg.stray_limit) begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = srd_pkg::KIND_SYNC;
                    end else begin
                        stray_next = stray_reg + 8'd1;
                    end
                end
                PH_TYPE:
                begin
                    if (rx_char >= srd_pkg::CHAR_0 && rx_char <= srd_pkg::CHAR_9
                        && rx_char != srd_pkg::CHAR_4) begin
                        type_next = type_off[3:0];
                    end else begin
                        type_next = srd_pkg::TYPE_BAD;
                        bad_next  = 1'b1;
                    end
                    phase_next = PH_COUNT;
                end
                PH_COUNT, PH_BODY:
                begin
                    if (!hex[4]) begin
                        bad_next = 1'b1;
                    end
                    if (!pend_reg) begin
                        high_next = hex[3:0];
                        pend_next = 1'b1;
                    end else begin
                        pend_next = 1'b0;
                        if (phase_reg == PH_COUNT) begin
                            length_next = byte_val;
                            left_next   = byte_val;
                            sum_next    = byte_val;
                            if (byte_val <= {5'd0, abytes} || byte_val > MAX_BYTES) begin
                                bad_next = 1'b1;
                            end
                            phase_next = (byte_val == 8'd0) ? PH_TERM1 : PH_BODY;
                        end else begin
                            left_next = left_dec;
                            sum_next  = sum_add;
                            if (left_dec == 8'd0) begin
                                // checksum byte closes the line
                                if (sum_add != srd_pkg::SUM_GOOD) begin
                                    bad_next = 1'b1;
                                end
                                phase_next = PH_TERM1;
                            end else if (pos < {5'd0, abytes}) begin
                                start_next = {start_reg[23:0], byte_val};
                            end else if (data_type) begin
                                index_next       = index_reg + 8'd1;
                                res_valid        = 1'b1;
                                res.kind         = srd_pkg::KIND_DATA;
                                res.byte_address = end_point[31:0];
                                res.data_value   = byte_val;
                            end
                        end
                    end
                end
                PH_TERM1:
                begin
                    phase_next = PH_TERM2;
                end
                PH_TERM2:
                begin
                    res_valid        = 1'b1;
                    res.byte_address = start_reg;
                    res.data_count   = index_reg;
                    if (bad_reg) begin
                        res.kind = srd_pkg::KIND_BAD;
                    end else if (data_type) begin
                        if (start_reg < cfg.region_start
                            || end_point >= {1'b0, cfg.region_end}) begin
                            res.kind = srd_pkg::KIND_RANGE;
                        end else begin
                            res.kind = srd_pkg::KIND_OK;
                        end
                    end else if (type_reg >= 4'd7 && type_reg <= 4'd9) begin
                        res.kind = srd_pkg::KIND_END;
                    end else begin
                        res.kind = srd_pkg::KIND_OK;
                    end
                    if (res.kind != srd_pkg::KIND_OK) begin
                        halted_next = 1'b1;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= 4'd0;
            left_reg   <= 8'd0;
            length_reg <= 8'd0;
            start_reg  <= 32'd0;
            high_reg   <= 4'd0;
            pend_reg   <= 1'b0;
            sum_reg    <= 8'd0;
            index_reg  <= 8'd0;
            stray_reg  <= 8'd0;
            bad_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            left_reg   <= left_next;
            length_reg <= length_next;
            start_reg  <= start_next;
            high_reg   <= high_next;
            pend_reg   <= pend_next;
            sum_reg    <= sum_next;
            index_reg  <= index_next;
            stray_reg  <= stray_next;
            bad_reg    <= bad_next;
            halted_reg <= halted_next;
        end
    end

    // once halted, stay halted until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("decoder left the halted state");

    // a halted decoder gives no result
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result produced while halted");

    // every line that reaches the second terminator gives a verdict
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !halted_reg && phase_reg == PH_TERM2) |-> (res_valid && res.kind != srd_pkg::KIND_DATA))
        else $error("line closed without a verdict");

    // data words only come out of the body of a data line
    a_data_body: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == srd_pkg::KIND_DATA) |-> (phase_reg == PH_BODY && data_type))
        else $error("data word outside a data record body");

endmodule
